[hdl/q4k_pkg.sv]
package q4k_pkg;

  // default number of weight bytes per quant beat
  localparam int BYTES_PER_ITEM_DEF = 4;
  // a 32-bit weight word holds at most four bytes
  localparam int MAX_LANES = 4;

  // field and datapath widths
  localparam int WORD_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int NIB_W   = 4;
  localparam int SCALE_W = 6;
  localparam int PROD1_W = 13;  // nibble times activation, signed
  localparam int PROD2_W = 18;  // times the 6-bit group scale, signed
  localparam int MULT_W  = 20;  // full product width before trimming
  localparam int LANE_W  = 19;  // low plus high product of one lane
  localparam int ACC_W   = 32;
  localparam int POS_W   = 5;
  localparam int OFF_W   = 7;   // byte offset within a block, mod 128

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(31);

  // beat kinds
  typedef enum logic {
    KIND_SCALE = 1'b0,
    KIND_QUANT = 1'b1
  } kind_t;

  typedef logic [SCALE_W-1:0] scale_t;
  // index 0: group 2p (low nibbles), index 1: group 2p+1 (high nibbles)
  typedef scale_t [1:0] scale_pair_t;
  typedef scale_pair_t [3:0] scale_set_t;

  // per-stage control travelling alongside the lane data
  typedef struct packed {
    logic valid;
    logic last;
    logic partial;
  } ctl_t;

  // unpack the 12 packed scale bytes into four pairs of 6-bit group scales
  function automatic scale_set_t unpack_scales(input logic [WORD_W-1:0] wa,
                                               input logic [WORD_W-1:0] wb,
                                               input logic [WORD_W-1:0] wc);
    logic [BYTE_W-1:0] s [12];
    scale_t g [8];
    scale_set_t r;
    for (int j = 0; j < 4; j++) begin
      s[j]     = wa[BYTE_W*j +: BYTE_W];
      s[j + 4] = wb[BYTE_W*j +: BYTE_W];
      s[j + 8] = wc[BYTE_W*j +: BYTE_W];
    end
    for (int k = 0; k < 4; k++) begin
      g[k]     = s[k][SCALE_W-1:0];
      g[k + 4] = {s[k][BYTE_W-1:SCALE_W], s[k + 8][NIB_W-1:0]};
    end
    for (int p = 0; p < 4; p++) begin
      r[p][0] = g[2*p];
      r[p][1] = g[2*p + 1];
    end
    return r;
  endfunction

endpackage

[hdl/q4k_lane.sv]
module q4k_lane
  import q4k_pkg::*;
(
  input  logic                     clk,
  input  logic                     adv,
  input  logic [BYTE_W-1:0]        weight,
  input  logic [BYTE_W-1:0]        act_lo,
  input  logic [BYTE_W-1:0]        act_hi,
  input  scale_t                   scale_lo,
  input  scale_t                   scale_hi,
  output logic signed [LANE_W-1:0] lane_sum
);

  logic signed [PROD1_W-1:0] p1_lo;
  logic signed [PROD1_W-1:0] p1_hi;
  scale_t                    sc_lo;
  scale_t                    sc_hi;
  logic signed [MULT_W-1:0]  m_lo;
  logic signed [MULT_W-1:0]  m_hi;
  logic signed [PROD2_W-1:0] p2_lo;
  logic signed [PROD2_W-1:0] p2_hi;

  // stage 1: unsigned nibble times signed activation
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_lo <= $signed({1'b0, weight[NIB_W-1:0]}) * $signed(act_lo);
      p1_hi <= $signed({1'b0, weight[BYTE_W-1:NIB_W]}) * $signed(act_hi);
      sc_lo <= scale_lo;
      sc_hi <= scale_hi;
    end
  end

  // stage 2: apply the group scale
  assign m_lo = p1_lo * $signed({1'b0, sc_lo});
  assign m_hi = p1_hi * $signed({1'b0, sc_hi});

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_lo <= m_lo[PROD2_W-1:0];
      p2_hi <= m_hi[PROD2_W-1:0];
    end
  end

  // lane contribution handed to the merge
  assign lane_sum = $signed({p2_lo[PROD2_W-1], p2_lo}) + $signed({p2_hi[PROD2_W-1], p2_hi});

endmodule

[hdl/q4k_merge.sv]
module q4k_merge
  import q4k_pkg::*;
#(
  parameter int LANES = MAX_LANES
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ctl_t                     s2_ctl,
  input  logic signed [LANE_W-1:0] lane_sum [LANES],
  output logic                     take,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ACC_W-1:0]  row_sum,
  output logic                     partial_block
);

  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_next;

  // add every lane into the running row sum
  always_comb begin
    acc_next = acc;
    for (int i = 0; i < LANES; i++) begin
      acc_next = acc_next + {{(ACC_W-LANE_W){lane_sum[i][LANE_W-1]}}, lane_sum[i]};
    end
  end

  // a row end waits only while the previous sum is still held
  assign take = s2_ctl.valid && !(s2_ctl.last && out_valid && out_stall);

  // accumulator and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      // a held result stays until taken; a new row end raises valid
      out_valid <= (take && s2_ctl.last) || (out_valid && out_stall);
      if (take) begin
        if (s2_ctl.last) begin
          acc <= '0;
        end else begin
          acc <= acc_next;
        end
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (take && s2_ctl.last) begin
      row_sum       <= $signed(acc_next);
      partial_block <= s2_ctl.partial;
    end
  end

endmodule

[hdl/q4k_block_int_dot_top.sv]
// Integer core of a 4-bit block-quantized dot product.
// Input channel (in_valid / in_stall): a beat with kind = 0 loads the 12
// packed scale bytes of a block from word_a..word_c; a beat with kind = 1
// carries packed weight nibbles in word_a and int8 activations in word_b
// (low nibbles) and word_c (high nibbles). last_of_row on a quant beat closes
// the row.
// Output channel (out_valid / out_stall): one beat per row with the wrapping
// 32-bit row_sum and partial_block, set when the row ended before the
// block's 32nd quant beat.
// Throughput: one beat per cycle while in_stall is low. Each weight byte
// has its own lane with a two-stage multiply (nibble times activation,
// then times the group scale), and a single accumulator adds all lanes
// once per cycle while beats are taken. The closing beat of a row passes
// the stage-1 and stage-2 registers; the merge stage registers the row sum.
// Reset clears the accumulator, the block position and all pipeline valids;
// the group scales hold nothing until the first scale beat.
// When the receiver stalls, the result stays in the output register and
// beats keep flowing until another row end reaches the merge stage; then
// in_stall rises until the held result is taken.
module q4k_block_int_dot_top
  import q4k_pkg::*;
#(
  parameter int BYTES_PER_ITEM = BYTES_PER_ITEM_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    kind,
  input  logic [WORD_W-1:0]       word_a,
  input  logic [WORD_W-1:0]       word_b,
  input  logic [WORD_W-1:0]       word_c,
  input  logic                    last_of_row,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [ACC_W-1:0] row_sum,
  output logic                    partial_block
);

  localparam int LANES = (BYTES_PER_ITEM > MAX_LANES) ? MAX_LANES : BYTES_PER_ITEM;

  logic                     accept;
  logic                     adv;
  logic                     take;
  logic                     is_quant;
  scale_set_t               scales;
  scale_pair_t              cur_pair;
  logic [POS_W-1:0]         item_pos;
  logic [OFF_W-1:0]         offset;
  logic [1:0]               pair;
  ctl_t                     s1_ctl;
  ctl_t                     s2_ctl;
  logic signed [LANE_W-1:0] lane_sum [LANES];

  // pipeline moves unless the merge stage is held
  assign adv      = !s2_ctl.valid || take;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign is_quant = (kind == KIND_QUANT);

  // group pair from the byte offset within the block
  assign offset   = {{(OFF_W-POS_W){1'b0}}, item_pos} * OFF_W'(BYTES_PER_ITEM);
  assign pair     = offset[OFF_W-1 -: 2];
  assign cur_pair = scales[pair];

  // scale store
  always_ff @(posedge clk) begin
    if (accept && !is_quant) begin
      scales <= unpack_scales(word_a, word_b, word_c);
    end
  end

  // stage control and block position
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl   <= '0;
      s2_ctl   <= '0;
      item_pos <= '0;
    end else if (adv) begin
      s1_ctl.valid   <= accept && is_quant;
      s1_ctl.last    <= last_of_row;
      s1_ctl.partial <= (item_pos != LAST_POS);
      s2_ctl         <= s1_ctl;
      if (accept && is_quant) begin
        item_pos <= last_of_row ? '0 : item_pos + POS_W'(1);
      end
    end
  end

  // one multiply lane per weight byte
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    q4k_lane u_lane (
      .clk      (clk),
      .adv      (adv),
      .weight   (word_a[BYTE_W*i +: BYTE_W]),
      .act_lo   (word_b[BYTE_W*i +: BYTE_W]),
      .act_hi   (word_c[BYTE_W*i +: BYTE_W]),
      .scale_lo (cur_pair[0]),
      .scale_hi (cur_pair[1]),
      .lane_sum (lane_sum[i])
    );
  end

  // accumulate and present row sums
  q4k_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .s2_ctl        (s2_ctl),
    .lane_sum      (lane_sum),
    .take          (take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .row_sum       (row_sum),
    .partial_block (partial_block)
  );

`ifndef SYNTHESIS
  a_block_on_held_row_end: assert property (@(posedge clk) disable iff (rst)
    (s2_ctl.valid && s2_ctl.last && out_valid && out_stall) |-> in_stall)
    else $error("row end entered merge while a result was held");

  a_quant_enters_pipe: assert property (@(posedge clk) disable iff (rst)
    (accept && is_quant) |=> s1_ctl.valid)
    else $error("accepted quant beat lost before the lanes");

  a_row_end_clears_pos: assert property (@(posedge clk) disable iff (rst)
    (accept && is_quant && last_of_row) |=> (item_pos == '0))
    else $error("block position not cleared at row end");

  a_scale_keeps_pos: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_quant) |=> $stable(item_pos))
    else $error("scale beat moved the block position");

  a_result_from_row_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s2_ctl.valid && s2_ctl.last))
    else $error("result raised without a row end");
`endif

endmodule
